[src/normal_to_spherical_angles_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the normal to spherical angles unit
// Immediate-consequence and next-cycle property checks with a reset guard.
// ----------------------------------------------------------------------------
`ifndef NORMAL_TO_SPHERICAL_ANGLES_UNIT_ASSERT_SVH
`define NORMAL_TO_SPHERICAL_ANGLES_UNIT_ASSERT_SVH

// Consequence holds in the same cycle as the antecedent.
`define NTSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define NTSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ntsa_pkg.sv]
// ----------------------------------------------------------------------------
// ntsa_pkg
// Widths, constants, types and the arctangent table of the angle unit.
// ----------------------------------------------------------------------------
package ntsa_pkg;

    localparam int IN_W         = 16;
    localparam int THETA_W      = 16;
    localparam int PHI_W        = 15;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int ATAN_IDX_W   = $clog2(ATAN_LEN);
    localparam int ATAN_BITS    = 32;
    localparam int NUM_STEPS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    // Square of a 16-bit signed value fits in 31 bits, the sum of two in 32
    localparam int SQ_W         = 2 * IN_W - 1;
    localparam int SUM_W        = SQ_W + 1;
    localparam int RAD_SHIFT    = 16;
    localparam int RAD_W        = SUM_W + RAD_SHIFT;
    localparam int ROOT_STEPS   = RAD_W / 2;
    localparam int ROOT_W       = ROOT_STEPS;

    // Vector coordinates: y is scaled by 2^8 to match the root, then all by 2^16.
    // Largest magnitude times CORDIC gain stays below 2^42.
    localparam int Y_SHIFT      = 8;
    localparam int VEC_SHIFT    = 16;
    localparam int VEC_W        = 44;

    // Angle accumulator: radians with 30 fraction bits, range about -1.8 to 3.4
    localparam int ACC_W        = 34;
    localparam int RND_SHIFT    = 17;
    localparam int ANG_W        = ACC_W - RND_SHIFT;

    localparam int NUM_LANES    = 2;
    localparam int LANE_THETA   = 0;
    localparam int LANE_PHI     = 1;

    typedef logic signed [VEC_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    localparam acc_t HALF_PI_ACC = acc_t'(34'h0_6487ED51);
    localparam acc_t ROUND_BIAS  = acc_t'(1) << (RND_SHIFT - 1);

    localparam int PI_Q13 = 25736;
    localparam logic [PHI_W-1:0] HALF_PI_Q13 = PHI_W'(12868);

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
    } ntsa_vec_t;

    typedef struct packed {
        logic neg_x;
        logic xz_zero;
        logic degen;
    } ntsa_flags_t;

    // atan(2^-i) in radians, 30 fraction bits
    function automatic logic [ATAN_BITS-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_BITS-1:0] val;
        case (idx)
            0:       val = 32'h3243F6A8;
            1:       val = 32'h1DAC6705;
            2:       val = 32'h0FADBAFC;
            3:       val = 32'h07F56EA6;
            4:       val = 32'h03FEAB76;
            5:       val = 32'h01FFD55B;
            6:       val = 32'h00FFFAAA;
            7:       val = 32'h007FFF55;
            8:       val = 32'h003FFFEA;
            9:       val = 32'h001FFFFD;
            10:      val = 32'h000FFFFF;
            11:      val = 32'h0007FFFF;
            12:      val = 32'h0003FFFF;
            13:      val = 32'h0001FFFF;
            14:      val = 32'h0000FFFF;
            15:      val = 32'h00007FFF;
            16:      val = 32'h00003FFF;
            17:      val = 32'h00001FFF;
            18:      val = 32'h00000FFF;
            19:      val = 32'h000007FF;
            20:      val = 32'h000003FF;
            21:      val = 32'h000001FF;
            22:      val = 32'h000000FF;
            23:      val = 32'h0000007F;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[src/ntsa_in_if.sv]
// ----------------------------------------------------------------------------
// ntsa_in_if
// Valid/ready channel that carries one surface normal per transaction.
// ----------------------------------------------------------------------------
interface ntsa_in_if;
    import ntsa_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] normal_x;
    logic signed [IN_W-1:0] normal_y;
    logic signed [IN_W-1:0] normal_z;

    modport source (
        output valid,
        output normal_x,
        output normal_y,
        output normal_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  normal_x,
        input  normal_y,
        input  normal_z,
        output ready
    );
endinterface

[src/ntsa_out_if.sv]
// ----------------------------------------------------------------------------
// ntsa_out_if
// Valid/ready channel that carries the two angles of one normal per transaction.
// ----------------------------------------------------------------------------
interface ntsa_out_if;
    import ntsa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [THETA_W-1:0] theta_angle;
    logic [PHI_W-1:0]          phi_angle;
    logic                      degenerate;

    modport source (
        output valid,
        output theta_angle,
        output phi_angle,
        output degenerate,
        input  ready
    );

    modport sink (
        input  valid,
        input  theta_angle,
        input  phi_angle,
        input  degenerate,
        output ready
    );
endinterface

[src/ntsa_front.sv]
// ----------------------------------------------------------------------------
// ntsa_front
// Input register, squares of x and z, and the radicand (x^2 + z^2) << 16.
// ----------------------------------------------------------------------------
module ntsa_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  ntsa_pkg::ntsa_vec_t        in_vec,
    output logic                       out_valid,
    output ntsa_pkg::ntsa_vec_t        out_vec,
    output logic [ntsa_pkg::RAD_W-1:0] radicand
);
    import ntsa_pkg::*;

    logic             valid0_reg;
    logic             valid1_reg;
    logic             valid2_reg;
    ntsa_vec_t        vec0_reg;
    ntsa_vec_t        vec1_reg;
    ntsa_vec_t        vec2_reg;
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqz_reg;
    logic [RAD_W-1:0] radicand_reg;

    logic signed [2*IN_W-1:0] prod_x;
    logic signed [2*IN_W-1:0] prod_z;
    logic [SQ_W-1:0]          sqx_next;
    logic [SQ_W-1:0]          sqz_next;
    logic [SUM_W-1:0]         sum_next;
    logic [RAD_W-1:0]         radicand_next;

    assign prod_x   = $signed(vec0_reg.x) * $signed(vec0_reg.x);
    assign prod_z   = $signed(vec0_reg.z) * $signed(vec0_reg.z);
    // A square is never negative and at most 2^30
    assign sqx_next = prod_x[SQ_W-1:0];
    assign sqz_next = prod_z[SQ_W-1:0];

    assign sum_next      = SUM_W'(sqx_reg) + SUM_W'(sqz_reg);
    assign radicand_next = {sum_next, {RAD_SHIFT{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid0_reg <= in_valid;
            valid1_reg <= valid0_reg;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec0_reg     <= in_vec;
            vec1_reg     <= vec0_reg;
            sqx_reg      <= sqx_next;
            sqz_reg      <= sqz_next;
            vec2_reg     <= vec1_reg;
            radicand_reg <= radicand_next;
        end
    end

    assign out_valid = valid2_reg;
    assign out_vec   = vec2_reg;
    assign radicand  = radicand_reg;

endmodule

[src/ntsa_isqrt.sv]
// ----------------------------------------------------------------------------
// ntsa_isqrt
// Pipelined integer square root, one root bit per stage (restoring method).
// ----------------------------------------------------------------------------
module ntsa_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  ntsa_pkg::ntsa_vec_t         in_vec,
    input  logic [ntsa_pkg::RAD_W-1:0]  radicand,
    output logic                        out_valid,
    output ntsa_pkg::ntsa_vec_t         out_vec,
    output logic [ntsa_pkg::ROOT_W-1:0] root
);
    import ntsa_pkg::*;

    logic             valid_reg [ROOT_STEPS];
    ntsa_vec_t        vec_reg   [ROOT_STEPS];
    logic [RAD_W-1:0] rem_reg   [ROOT_STEPS];
    logic [RAD_W-1:0] res_reg   [ROOT_STEPS];

    logic [RAD_W-1:0] rem_in    [ROOT_STEPS];
    logic [RAD_W-1:0] res_in    [ROOT_STEPS];
    logic [RAD_W-1:0] rem_next  [ROOT_STEPS];
    logic [RAD_W-1:0] res_next  [ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_step
        localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);

        logic [RAD_W-1:0] trial;
        logic             fits;

        if (k == 0)
        begin : g_head
            assign rem_in[k] = radicand;
            assign res_in[k] = '0;
        end
        else
        begin : g_body
            assign rem_in[k] = rem_reg[k-1];
            assign res_in[k] = res_reg[k-1];
        end

        // Subtract the trial value where it fits and set this root bit
        assign trial       = res_in[k] + STEP_BIT;
        assign fits        = rem_in[k] >= trial;
        assign rem_next[k] = fits ? rem_in[k] - trial : rem_in[k];
        assign res_next[k] = fits ? (res_in[k] >> 1) + STEP_BIT : res_in[k] >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < ROOT_STEPS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg[0] <= in_vec;
            for (int k = 1; k < ROOT_STEPS; k++)
            begin
                vec_reg[k] <= vec_reg[k-1];
            end
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_STEPS-1];
    assign out_vec   = vec_reg[ROOT_STEPS-1];
    assign root      = res_reg[ROOT_STEPS-1][ROOT_W-1:0];

endmodule

[src/ntsa_cordic.sv]
// ----------------------------------------------------------------------------
// ntsa_cordic
// Unrolled CORDIC vectoring for the theta and phi vectors side by side:
// one quarter-turn pre-rotation stage, then one stage per micro-rotation.
// ----------------------------------------------------------------------------
module ntsa_cordic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  ntsa_pkg::ntsa_vec_t         in_vec,
    input  logic [ntsa_pkg::ROOT_W-1:0] root,
    output logic                        out_valid,
    output ntsa_pkg::ntsa_flags_t       flags,
    output ntsa_pkg::acc_t              theta_acc,
    output ntsa_pkg::acc_t              phi_acc
);
    import ntsa_pkg::*;

    logic        valid_reg [NUM_STEPS+1];
    ntsa_flags_t flags_reg [NUM_STEPS+1];
    coord_t      px_reg    [NUM_STEPS+1][NUM_LANES];
    coord_t      py_reg    [NUM_STEPS+1][NUM_LANES];
    acc_t        acc_reg   [NUM_STEPS+1][NUM_LANES];

    logic [IN_W:0] x_ext;
    logic [IN_W:0] abs_x;
    coord_t        px_src   [NUM_LANES];
    coord_t        py_src   [NUM_LANES];
    ntsa_flags_t   flags0_next;
    coord_t        px0_next [NUM_LANES];
    coord_t        py0_next [NUM_LANES];
    acc_t          acc0_next[NUM_LANES];
    coord_t        px_next  [NUM_STEPS][NUM_LANES];
    coord_t        py_next  [NUM_STEPS][NUM_LANES];
    acc_t          acc_next [NUM_STEPS][NUM_LANES];

    assign x_ext = {in_vec.x[IN_W-1], in_vec.x};
    assign abs_x = x_ext[IN_W] ? ~x_ext + 1'b1 : x_ext;

    // Theta works on (z, |x|), phi on (y << 8, root); both scaled by 2^16
    assign px_src[LANE_THETA] = {{(VEC_W-IN_W-VEC_SHIFT){in_vec.z[IN_W-1]}},
                                 in_vec.z, {VEC_SHIFT{1'b0}}};
    assign py_src[LANE_THETA] = {{(VEC_W-IN_W-1-VEC_SHIFT){1'b0}},
                                 abs_x, {VEC_SHIFT{1'b0}}};
    assign px_src[LANE_PHI]   = {{(VEC_W-IN_W-Y_SHIFT-VEC_SHIFT){in_vec.y[IN_W-1]}},
                                 in_vec.y, {(Y_SHIFT+VEC_SHIFT){1'b0}}};
    assign py_src[LANE_PHI]   = {{(VEC_W-ROOT_W-VEC_SHIFT){1'b0}},
                                 root, {VEC_SHIFT{1'b0}}};

    assign flags0_next.neg_x   = in_vec.x[IN_W-1];
    assign flags0_next.xz_zero = (in_vec.x == '0) && (in_vec.z == '0);
    assign flags0_next.degen   = (in_vec.x == '0) && (in_vec.z == '0) && (in_vec.y == '0);

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_pre
        logic turn;

        // Turn a vector in the left half-plane by a quarter first
        assign turn         = px_src[l][VEC_W-1];
        assign px0_next[l]  = turn ? py_src[l] : px_src[l];
        assign py0_next[l]  = turn ? -px_src[l] : py_src[l];
        assign acc0_next[l] = turn ? HALF_PI_ACC : '0;
    end

    for (genvar j = 0; j < NUM_STEPS; j++)
    begin : g_rot
        localparam acc_t ATAN_J = acc_t'(atan_entry(ATAN_IDX_W'(j)));

        for (genvar l = 0; l < NUM_LANES; l++)
        begin : g_lane
            coord_t dx;
            coord_t dy;
            logic   up;

            assign dx = py_reg[j][l] >>> j;
            assign dy = px_reg[j][l] >>> j;
            // A residual of exactly zero rotates the other way
            assign up = !py_reg[j][l][VEC_W-1] && (py_reg[j][l] != '0);

            assign px_next[j][l]  = up ? px_reg[j][l] + dx : px_reg[j][l] - dx;
            assign py_next[j][l]  = up ? py_reg[j][l] - dy : py_reg[j][l] + dy;
            assign acc_next[j][l] = up ? acc_reg[j][l] + ATAN_J : acc_reg[j][l] - ATAN_J;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NUM_STEPS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s <= NUM_STEPS; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg[0] <= flags0_next;
            for (int s = 1; s <= NUM_STEPS; s++)
            begin
                flags_reg[s] <= flags_reg[s-1];
            end
            for (int l = 0; l < NUM_LANES; l++)
            begin
                px_reg[0][l]  <= px0_next[l];
                py_reg[0][l]  <= py0_next[l];
                acc_reg[0][l] <= acc0_next[l];
                for (int s = 0; s < NUM_STEPS; s++)
                begin
                    px_reg[s+1][l]  <= px_next[s][l];
                    py_reg[s+1][l]  <= py_next[s][l];
                    acc_reg[s+1][l] <= acc_next[s][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[NUM_STEPS];
    assign flags     = flags_reg[NUM_STEPS];
    assign theta_acc = acc_reg[NUM_STEPS][LANE_THETA];
    assign phi_acc   = acc_reg[NUM_STEPS][LANE_PHI];

endmodule

[src/normal_to_spherical_angles_unit.sv]
// ----------------------------------------------------------------------------
// normal_to_spherical_angles_unit
// Converts a surface normal (x, y, z in signed Q1.15) into theta, the angle
// atan2(|x|, z) carrying the sign of x, and phi = acos(y / |v|), both radians
// in Q3.13, plus a flag for the all-zero vector (phi 0, theta +pi/2). The unit
// is a fully pipelined datapath that accepts one normal every clock cycle
// while normal.ready is high. From an accepted normal to its result on the
// output register it passes three front stages (input, squares, sum), 24
// square-root stages at one root bit each, one quarter-turn stage, one stage
// per CORDIC micro-rotation, and the output register. A skid register behind
// the output keeps the pipeline moving for one result while the output is
// stalled; normal.ready drops only while that skid holds data.
// ----------------------------------------------------------------------------
`include "normal_to_spherical_angles_unit_assert.svh"

module normal_to_spherical_angles_unit (
    input  logic              clk,
    input  logic              rst_n,
    ntsa_in_if.sink           normal,
    ntsa_out_if.source        angles
);
    import ntsa_pkg::*;

    typedef struct packed {
        logic signed [THETA_W-1:0] theta;
        logic [PHI_W-1:0]          phi;
        logic                      degen;
    } result_t;

    logic        en;
    ntsa_vec_t   in_vec;

    logic             front_valid;
    ntsa_vec_t        front_vec;
    logic [RAD_W-1:0] radicand;

    logic              root_valid;
    ntsa_vec_t         root_vec;
    logic [ROOT_W-1:0] root;

    logic        pipe_valid;
    ntsa_flags_t pipe_flags;
    acc_t        theta_acc;
    acc_t        phi_acc;

    logic [PHI_W-1:0]   theta_mag;
    logic [THETA_W-1:0] theta_wide;
    result_t            result;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;

    // Round half up to Q3.13 and clamp to [0, pi]
    function automatic logic [PHI_W-1:0] to_q13(input acc_t acc);
        acc_t                    biased;
        logic signed [ANG_W-1:0] coarse;
        logic [PHI_W-1:0]        val;
        biased = acc + ROUND_BIAS;
        coarse = biased[ACC_W-1:RND_SHIFT];
        if (coarse < 0)
        begin
            val = '0;
        end
        else if (coarse > PI_Q13)
        begin
            val = PHI_W'(PI_Q13);
        end
        else
        begin
            val = PHI_W'(coarse);
        end
        return val;
    endfunction

    assign en           = !skid_valid_reg;
    assign normal.ready = en;
    assign in_vec       = '{x: normal.normal_x, y: normal.normal_y, z: normal.normal_z};

    ntsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (normal.valid),
        .in_vec    (in_vec),
        .out_valid (front_valid),
        .out_vec   (front_vec),
        .radicand  (radicand)
    );

    ntsa_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_vec    (front_vec),
        .radicand  (radicand),
        .out_valid (root_valid),
        .out_vec   (root_vec),
        .root      (root)
    );

    ntsa_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_valid),
        .in_vec    (root_vec),
        .root      (root),
        .out_valid (pipe_valid),
        .flags     (pipe_flags),
        .theta_acc (theta_acc),
        .phi_acc   (phi_acc)
    );

    assign theta_mag    = pipe_flags.xz_zero ? HALF_PI_Q13 : to_q13(theta_acc);
    assign theta_wide   = {1'b0, theta_mag};
    assign result.theta = pipe_flags.neg_x ? -theta_wide : theta_wide;
    assign result.phi   = pipe_flags.degen ? '0 : to_q13(phi_acc);
    assign result.degen = pipe_flags.degen;

    assign take = out_valid_reg && angles.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // Pipeline is frozen; drain the skid once the output is taken
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_valid)
        begin
            if (out_valid_reg && !angles.ready)
            begin
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign angles.valid       = out_valid_reg;
    assign angles.theta_angle = out_data_reg.theta;
    assign angles.phi_angle   = out_data_reg.phi;
    assign angles.degenerate  = out_data_reg.degen;

    `NTSA_ASSERT_SAME(a_skid_behind_output, clk, rst_n, skid_valid_reg, out_valid_reg, "skid holds a result while the output register is empty")
    `NTSA_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && !angles.ready, skid_valid_reg && $stable(skid_data_reg), "skid result lost or changed during a stall")
    `NTSA_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, out_valid_reg && !angles.ready && pipe_valid && !skid_valid_reg, skid_valid_reg, "pipeline result dropped while the output was stalled")
    `NTSA_ASSERT_SAME(a_degenerate_angles, clk, rst_n, angles.valid && angles.degenerate, angles.phi_angle == '0 && angles.theta_angle == THETA_W'(HALF_PI_Q13), "zero vector gives wrong angles")
    `NTSA_ASSERT_SAME(a_angle_range, clk, rst_n, angles.valid, angles.theta_angle >= -PI_Q13 && angles.theta_angle <= PI_Q13 && angles.phi_angle <= PI_Q13, "angle outside [-pi, pi]")

endmodule
